>>> rtl/core/ezrm_pkg.sv
package ezrm_pkg;

  // Default configuration.
  localparam int unsigned CORDIC_STEPS_DEF  = 16;
  localparam int unsigned OUT_FRAC_BITS_DEF = 14;

  // Field and datapath widths.
  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned K_W     = 46;
  localparam int unsigned K_LO_W  = 23;
  localparam int unsigned K_HI_W  = K_W - K_LO_W;
  localparam int unsigned PH_W    = 32;
  localparam int unsigned XY_W    = 34;
  localparam int unsigned Z_W     = 32;
  localparam int unsigned TRIG_W  = 32;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned SUM_W   = 34;
  localparam int unsigned N_ENTRY = 9;

  // Turns per unit angle in Q48 (radians and degrees).
  localparam logic [K_W-1:0] K_RAD = 46'd44798133900177;
  localparam logic [K_W-1:0] K_DEG = 46'd781874935307;

  // pi/2 in Q30 and the CORDIC gain compensation in Q30.
  localparam logic [30:0]             HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 34'sh0_26DD_3B6A;

  // Arctangent of 2^-i in Q30.
  localparam logic signed [Z_W-1:0] ATAN_Q30 [32] = '{
    32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6, 32'sh03FEAB76,
    32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55, 32'sh003FFFEA, 32'sh001FFFFD,
    32'sh000FFFFF, 32'sh0007FFFF, 32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF,
    32'sh00007FFF, 32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
    32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F, 32'sh0000003F,
    32'sh0000001F, 32'sh0000000F, 32'sh00000008, 32'sh00000004, 32'sh00000002,
    32'sh00000001, 32'sh00000000
  };

  // Sine and cosine of one angle, Q30.
  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } sc_t;

  // Round a Q60 product back to Q30, halves towards plus infinity.
  function automatic logic signed [TRIG_W-1:0] rnd30(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    t = v + 64'sd536870912;
    return t[TRIG_W+29:30];
  endfunction

endpackage

>>> rtl/core/ezrm_if.sv
// Angle channel.
interface ezrm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ezrm_pkg::ANGLE_W-1:0]  angle_a;
  logic signed [ezrm_pkg::ANGLE_W-1:0]  angle_b;
  logic signed [ezrm_pkg::ANGLE_W-1:0]  angle_c;
  logic                                 angles_in_degrees;

  modport source(output valid, output angle_a, output angle_b, output angle_c,
                 output angles_in_degrees, input ready);
  modport sink(input valid, input angle_a, input angle_b, input angle_c,
               input angles_in_degrees, output ready);
endinterface

// Matrix channel.
interface ezrm_out_if #(
  parameter int unsigned OUT_W = ezrm_pkg::OUT_FRAC_BITS_DEF + 2
);
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] entry_r0c0;
  logic signed [OUT_W-1:0] entry_r0c1;
  logic signed [OUT_W-1:0] entry_r0c2;
  logic signed [OUT_W-1:0] entry_r1c0;
  logic signed [OUT_W-1:0] entry_r1c1;
  logic signed [OUT_W-1:0] entry_r1c2;
  logic signed [OUT_W-1:0] entry_r2c0;
  logic signed [OUT_W-1:0] entry_r2c1;
  logic signed [OUT_W-1:0] entry_r2c2;

  modport source(output valid, output entry_r0c0, output entry_r0c1, output entry_r0c2,
                 output entry_r1c0, output entry_r1c1, output entry_r1c2,
                 output entry_r2c0, output entry_r2c1, output entry_r2c2, input ready);
  modport sink(input valid, input entry_r0c0, input entry_r0c1, input entry_r0c2,
               input entry_r1c0, input entry_r1c1, input entry_r1c2,
               input entry_r2c0, input entry_r2c1, input entry_r2c2, output ready);
endinterface

>>> rtl/core/euler_zxy_rotation_matrix.sv
// An angle transfer reaches its matrix through the registered stages of the
// three sine/cosine lanes and then those of the merge.
// Throughput: one transfer per cycle on each side; the whole pipeline holds
// while a finished matrix waits on a stalled output.
// Reset: rst_ni clears the valid bits of every stage asynchronously; the data
// registers are not reset.
module euler_zxy_rotation_matrix #(
  parameter int unsigned CORDIC_STEPS  = ezrm_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned OUT_FRAC_BITS = ezrm_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ezrm_in_if.sink           ang_i,
  ezrm_out_if.source        mat_o
);

  // Each angle has its own sine/cosine lane: the phase is formed with two
  // partial products, folded to one quadrant, scaled to a Q2.30 angle and
  // rotated through one registered CORDIC stage per step. The merge then forms
  // the nine entries of the ZXY matrix in registered stages: pair products,
  // rounding, triple products, rounding, sums, output rounding and clamping.
  localparam int unsigned LANE_LAT  = CORDIC_STEPS + 5;
  localparam int unsigned MERGE_LAT = 6;
  localparam int unsigned DEPTH     = LANE_LAT + MERGE_LAT;
  localparam int unsigned OUT_W     = OUT_FRAC_BITS + 2;
  localparam logic signed [OUT_W-1:0] LIM   = OUT_W'(1) <<< OUT_FRAC_BITS;
  localparam logic signed [OUT_W-1:0] LIM_N = -LIM;

  // All stages advance together. They move whenever the output register is
  // empty or its matrix is being transferred out in this cycle, so a new
  // angle transfer is taken in every cycle while the consumer keeps up.
  logic             en;
  logic             in_xfer;
  logic [DEPTH-1:0] vld_d, vld_q;

  assign en          = !vld_q[DEPTH-1] || mat_o.ready;
  assign ang_i.ready = en;
  assign in_xfer     = ang_i.valid && en;

  // Valid bits travel alongside the data; a bubble occupies its stage.
  assign vld_d = en ? {vld_q[DEPTH-2:0], ang_i.valid} : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Three lanes, one for each angle.
  logic signed [ezrm_pkg::ANGLE_W-1:0] angle [3];
  ezrm_pkg::sc_t                       sc [3];

  assign angle[0] = ang_i.angle_a;
  assign angle[1] = ang_i.angle_b;
  assign angle[2] = ang_i.angle_c;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    ezrm_sincos #(
      .CORDIC_STEPS(CORDIC_STEPS)
    ) u_sincos (
      .clk_i  (clk_i),
      .en_i   (en),
      .angle_i(angle[l]),
      .deg_i  (ang_i.angles_in_degrees),
      .sc_o   (sc[l])
    );
  end

  // Merge the three lanes into the matrix; its last stage is the output
  // register.
  logic signed [OUT_W-1:0] entry [ezrm_pkg::N_ENTRY];

  ezrm_merge #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_merge (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (sc[0]),
    .b_i    (sc[1]),
    .c_i    (sc[2]),
    .entry_o(entry)
  );

  assign mat_o.valid      = vld_q[DEPTH-1];
  assign mat_o.entry_r0c0 = entry[0];
  assign mat_o.entry_r0c1 = entry[1];
  assign mat_o.entry_r0c2 = entry[2];
  assign mat_o.entry_r1c0 = entry[3];
  assign mat_o.entry_r1c1 = entry[4];
  assign mat_o.entry_r1c2 = entry[5];
  assign mat_o.entry_r2c0 = entry[6];
  assign mat_o.entry_r2c1 = entry[7];
  assign mat_o.entry_r2c2 = entry[8];

  // Every entry leaves the clamp within plus or minus one.
  logic ent_ok;

  always_comb begin
    ent_ok = 1'b1;
    for (int k = 0; k < ezrm_pkg::N_ENTRY; k++) begin
      if (entry[k] > LIM || entry[k] < LIM_N) begin
        ent_ok = 1'b0;
      end
    end
  end

  // While reset is held no stage carries a valid item.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> (vld_q == '0))
    else $error("pipeline holds valid items during reset");

  // A stalled pipeline neither loses nor invents items.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid bits moved while the pipeline was stalled");

  // An accepted angle set enters the first stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> vld_q[0])
    else $error("accepted transfer did not enter the pipeline");

  // Offered matrices are clamped.
  a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mat_o.valid |-> ent_ok)
    else $error("matrix entry beyond plus or minus one");

endmodule

>>> rtl/core/ezrm_sincos.sv
module ezrm_sincos #(
  parameter int unsigned CORDIC_STEPS = ezrm_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [ezrm_pkg::ANGLE_W-1:0] angle_i,
  input  logic                                deg_i,
  output ezrm_pkg::sc_t                       sc_o
);

  localparam int unsigned P_W  = ezrm_pkg::ANGLE_W + ezrm_pkg::K_LO_W + 1;
  localparam int unsigned ZP_W = 30 + 32;
  localparam int unsigned XY_W = ezrm_pkg::XY_W;
  localparam int unsigned Z_W  = ezrm_pkg::Z_W;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  // Phase multiply, split into two partial products.
  logic [ezrm_pkg::K_W-1:0] k_sel;
  logic signed [P_W-1:0]    p_lo_d, p_lo_q, p_hi_d, p_hi_q;

  assign k_sel  = deg_i ? ezrm_pkg::K_DEG : ezrm_pkg::K_RAD;
  assign p_lo_d = angle_i * $signed({1'b0, k_sel[ezrm_pkg::K_LO_W-1:0]});
  assign p_hi_d = angle_i * $signed({1'b0, k_sel[ezrm_pkg::K_W-1:ezrm_pkg::K_LO_W]});

  // Phase as a Q0.32 fraction of a turn.
  logic [63:0]                   ph_sum;
  logic [ezrm_pkg::PH_W-1:0]     phase_d, phase_q;

  assign ph_sum = {{(64 - P_W){p_lo_q[P_W-1]}}, p_lo_q}
                + {p_hi_q[64-ezrm_pkg::K_LO_W-1:0], {ezrm_pkg::K_LO_W{1'b0}}}
                + 64'h0000_0000_8000_0000;
  assign phase_d = ph_sum[63:32];

  // Quadrant and residual; the residual is the low 30 bits read as signed.
  logic [1:0]             quad_d, quad_q;
  logic signed [ZP_W-1:0] zp_d, zp_q, zr;
  logic signed [Z_W-1:0]  z0;

  assign quad_d = phase_q[31:30] + {1'b0, phase_q[29]};
  assign zp_d   = $signed(phase_q[29:0]) * $signed({1'b0, ezrm_pkg::HALF_PI_Q30});
  assign zr     = zp_q + 62'sd536870912;
  assign z0     = zr[Z_W+29:30];

  // CORDIC stage registers; index 0 is the seed.
  logic signed [XY_W-1:0] x_q [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] y_q [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  z_q [CORDIC_STEPS+1];
  logic [1:0]             q_q [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] x_d [CORDIC_STEPS];
  logic signed [XY_W-1:0] y_d [CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_d [CORDIC_STEPS];

  always_comb begin
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (!z_q[i][Z_W-1]) begin
        x_d[i] = x_q[i] - (y_q[i] >>> i);
        y_d[i] = y_q[i] + (x_q[i] >>> i);
        z_d[i] = z_q[i] - ezrm_pkg::ATAN_Q30[i];
      end else begin
        x_d[i] = x_q[i] + (y_q[i] >>> i);
        y_d[i] = y_q[i] - (x_q[i] >>> i);
        z_d[i] = z_q[i] + ezrm_pkg::ATAN_Q30[i];
      end
    end
  end

  // Quadrant fold back onto the full circle.
  ezrm_pkg::sc_t sc_d, sc_q;
  logic signed [XY_W-1:0] xf, yf;

  assign xf = x_q[CORDIC_STEPS];
  assign yf = y_q[CORDIC_STEPS];

  always_comb begin
    case (q_q[CORDIC_STEPS])
      QUAD_0: begin
        sc_d.cos_v = xf[ezrm_pkg::TRIG_W-1:0];
        sc_d.sin_v = yf[ezrm_pkg::TRIG_W-1:0];
      end
      QUAD_1: begin
        sc_d.cos_v = ezrm_pkg::TRIG_W'(-yf);
        sc_d.sin_v = xf[ezrm_pkg::TRIG_W-1:0];
      end
      QUAD_2: begin
        sc_d.cos_v = ezrm_pkg::TRIG_W'(-xf);
        sc_d.sin_v = ezrm_pkg::TRIG_W'(-yf);
      end
      default: begin
        sc_d.cos_v = yf[ezrm_pkg::TRIG_W-1:0];
        sc_d.sin_v = ezrm_pkg::TRIG_W'(-xf);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_lo_q  <= p_lo_d;
      p_hi_q  <= p_hi_d;
      phase_q <= phase_d;
      quad_q  <= quad_d;
      zp_q    <= zp_d;
      x_q[0]  <= ezrm_pkg::CORDIC_GAIN;
      y_q[0]  <= '0;
      z_q[0]  <= z0;
      q_q[0]  <= quad_q;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        x_q[i+1] <= x_d[i];
        y_q[i+1] <= y_d[i];
        z_q[i+1] <= z_d[i];
        q_q[i+1] <= q_q[i];
      end
      sc_q <= sc_d;
    end
  end

  assign sc_o = sc_q;

endmodule

>>> rtl/core/ezrm_merge.sv
module ezrm_merge #(
  parameter int unsigned OUT_FRAC_BITS = ezrm_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  ezrm_pkg::sc_t                 a_i,
  input  ezrm_pkg::sc_t                 b_i,
  input  ezrm_pkg::sc_t                 c_i,
  output logic signed [OUT_FRAC_BITS+1:0] entry_o [ezrm_pkg::N_ENTRY]
);

  localparam int unsigned OUT_W  = OUT_FRAC_BITS + 2;
  localparam int unsigned TW     = ezrm_pkg::TRIG_W;
  localparam int unsigned PW     = ezrm_pkg::PROD_W;
  localparam int unsigned SW     = ezrm_pkg::SUM_W;
  localparam int unsigned SHIFT  = 30 - OUT_FRAC_BITS;
  localparam int          HALF   = (SHIFT == 0) ? 0 : (1 << (SHIFT - 1));
  localparam logic signed [SW-1:0] RND   = SW'(HALF);
  localparam logic signed [SW-1:0] LIM   = SW'(1) <<< OUT_FRAC_BITS;
  localparam logic signed [SW-1:0] LIM_N = -LIM;

  // Pair product slots.
  localparam int unsigned P_CACC = 0;
  localparam int unsigned P_SASB = 1;
  localparam int unsigned P_CASC = 2;
  localparam int unsigned P_CCSA = 3;
  localparam int unsigned P_CASB = 4;
  localparam int unsigned P_SASC = 5;
  localparam int unsigned P_CBSA = 6;
  localparam int unsigned P_CACB = 7;
  localparam int unsigned P_CBSC = 8;
  localparam int unsigned P_CBCC = 9;
  localparam int unsigned N_PAIR = 10;

  // Triple product slots.
  localparam int unsigned T_R0C0 = 0;
  localparam int unsigned T_R0C2 = 1;
  localparam int unsigned T_R1C0 = 2;
  localparam int unsigned T_R1C2 = 3;
  localparam int unsigned N_TRIP = 4;

  // Entry slots, row major.
  localparam int unsigned E_R0C0 = 0;
  localparam int unsigned E_R0C1 = 1;
  localparam int unsigned E_R0C2 = 2;
  localparam int unsigned E_R1C0 = 3;
  localparam int unsigned E_R1C1 = 4;
  localparam int unsigned E_R1C2 = 5;
  localparam int unsigned E_R2C0 = 6;
  localparam int unsigned E_R2C1 = 7;
  localparam int unsigned E_R2C2 = 8;

  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] o;
    o = (v + RND) >>> SHIFT;
    if (o > LIM) begin
      o = LIM;
    end else if (o < LIM_N) begin
      o = LIM_N;
    end
    return o[OUT_W-1:0];
  endfunction

  // Stage 1: pair products.
  logic signed [PW-1:0] p_d [N_PAIR];
  logic signed [PW-1:0] p_q [N_PAIR];
  logic signed [TW-1:0] sb1_q, sc1_q;

  always_comb begin
    p_d[P_CACC] = $signed(a_i.cos_v) * $signed(c_i.cos_v);
    p_d[P_SASB] = $signed(a_i.sin_v) * $signed(b_i.sin_v);
    p_d[P_CASC] = $signed(a_i.cos_v) * $signed(c_i.sin_v);
    p_d[P_CCSA] = $signed(c_i.cos_v) * $signed(a_i.sin_v);
    p_d[P_CASB] = $signed(a_i.cos_v) * $signed(b_i.sin_v);
    p_d[P_SASC] = $signed(a_i.sin_v) * $signed(c_i.sin_v);
    p_d[P_CBSA] = $signed(b_i.cos_v) * $signed(a_i.sin_v);
    p_d[P_CACB] = $signed(a_i.cos_v) * $signed(b_i.cos_v);
    p_d[P_CBSC] = $signed(b_i.cos_v) * $signed(c_i.sin_v);
    p_d[P_CBCC] = $signed(b_i.cos_v) * $signed(c_i.cos_v);
  end

  // Stage 2: pair products rounded to Q30.
  logic signed [TW-1:0] pr_q [N_PAIR];
  logic signed [TW-1:0] sb2_q, sc2_q;

  // Stage 3: triple products.
  logic signed [PW-1:0] t_d [N_TRIP];
  logic signed [PW-1:0] t_q [N_TRIP];
  logic signed [TW-1:0] pr3_q [N_PAIR];
  logic signed [TW-1:0] sb3_q;

  always_comb begin
    t_d[T_R0C0] = pr_q[P_SASB] * sc2_q;
    t_d[T_R0C2] = pr_q[P_CCSA] * sb2_q;
    t_d[T_R1C0] = pr_q[P_CASB] * sc2_q;
    t_d[T_R1C2] = pr_q[P_CACC] * sb2_q;
  end

  // Stage 4: triple products rounded to Q30.
  logic signed [TW-1:0] tr_q [N_TRIP];
  logic signed [TW-1:0] pr4_q [N_PAIR];
  logic signed [TW-1:0] sb4_q;

  // Stage 5: entry sums in Q30.
  logic signed [SW-1:0] s_d [ezrm_pkg::N_ENTRY];
  logic signed [SW-1:0] s_q [ezrm_pkg::N_ENTRY];

  always_comb begin
    s_d[E_R0C0] = SW'(pr4_q[P_CACC]) - SW'(tr_q[T_R0C0]);
    s_d[E_R0C1] = -SW'(pr4_q[P_CBSA]);
    s_d[E_R0C2] = SW'(pr4_q[P_CASC]) + SW'(tr_q[T_R0C2]);
    s_d[E_R1C0] = SW'(pr4_q[P_CCSA]) + SW'(tr_q[T_R1C0]);
    s_d[E_R1C1] = SW'(pr4_q[P_CACB]);
    s_d[E_R1C2] = SW'(pr4_q[P_SASC]) - SW'(tr_q[T_R1C2]);
    s_d[E_R2C0] = -SW'(pr4_q[P_CBSC]);
    s_d[E_R2C1] = SW'(sb4_q);
    s_d[E_R2C2] = SW'(pr4_q[P_CBCC]);
  end

  // Stage 6: rounded and clamped entries.
  logic signed [OUT_W-1:0] e_q [ezrm_pkg::N_ENTRY];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= p_d;
      sb1_q <= b_i.sin_v;
      sc1_q <= c_i.sin_v;
      for (int k = 0; k < N_PAIR; k++) begin
        pr_q[k] <= ezrm_pkg::rnd30(p_q[k]);
      end
      sb2_q <= sb1_q;
      sc2_q <= sc1_q;
      t_q   <= t_d;
      pr3_q <= pr_q;
      sb3_q <= sb2_q;
      for (int k = 0; k < N_TRIP; k++) begin
        tr_q[k] <= ezrm_pkg::rnd30(t_q[k]);
      end
      pr4_q <= pr3_q;
      sb4_q <= sb3_q;
      s_q   <= s_d;
      for (int k = 0; k < ezrm_pkg::N_ENTRY; k++) begin
        e_q[k] <= to_out(s_q[k]);
      end
    end
  end

  assign entry_o = e_q;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ezrm_pkg::*;

  localparam int unsigned STEPS     = CORDIC_STEPS_DEF;
  localparam int unsigned FRAC      = OUT_FRAC_BITS_DEF;
  localparam int unsigned OUT_W     = FRAC + 2;
  // The depth of the pipeline that an angle transfer passes through to the matrix side.
  localparam int unsigned LATENCY   = STEPS + 11;
  // Far above the slowest legal run: every transfer paying the longest gap
  // on the angle side and the longest stall on the matrix side.
  localparam int unsigned MAX_CYCLES = 200000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int          Q16_ONE     = 65536;

  // The nine entries of one matrix, entry 0 being r0c0 and entry 8 r2c2.
  typedef logic [N_ENTRY-1:0][OUT_W-1:0] matrix_t;

  logic clk;
  logic rst_n;
  bit   quiet;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;

  matrix_t expected_mats[$];

  string entry_names [N_ENTRY] = '{
    "r0c0", "r0c1", "r0c2", "r1c0", "r1c1", "r1c2", "r2c0", "r2c1", "r2c2"
  };

  ezrm_in_if  ang_if ();
  ezrm_out_if #(.OUT_W(OUT_W)) mat_if ();

  euler_zxy_rotation_matrix #(
    .CORDIC_STEPS  (STEPS),
    .OUT_FRAC_BITS (FRAC)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .ang_i  (ang_if),
    .mat_o  (mat_if)
  );

  // A 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // The watchdog: a run that hangs is a failed run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor of the matrix. Every rounding shift adds half an LSB and then
  // floors, so exact halves go towards plus infinity.
  // ---------------------------------------------------------------------------
  function automatic longint round_shr(input longint v, input int unsigned s);
    longint half;
    if (s == 0) return v;
    half = longint'(1) <<< (s - 1);
    return (v + half) >>> s;
  endfunction

  function automatic longint mul_q30(input longint a, input longint b);
    return round_shr(a * b, 30);
  endfunction

  // Sine and cosine of one angle in Q30. The angle is first turned into a
  // phase, a Q0.32 fraction of a full turn, so any 32-bit pattern simply
  // wraps. The phase is split into a quadrant and a residual of at most an
  // eighth of a turn either way, and the CORDIC only ever sees the residual.
  function automatic void angle_sin_cos(input logic signed [ANGLE_W-1:0] angle,
                                        input logic in_degrees,
                                        output longint sin_q30,
                                        output longint cos_q30);
    longint      turns_per_unit;
    longint      resid;
    longint      z;
    longint      cx;
    longint      cy;
    longint      dx;
    longint      dy;
    logic [63:0] turn_prod;
    logic [31:0] phase;
    logic [31:0] biased;
    logic [31:0] resid_u;
    logic [1:0]  quadrant;
    turns_per_unit = in_degrees ? longint'(K_DEG) : longint'(K_RAD);
    turn_prod = longint'(angle) * turns_per_unit + 64'h0000_0000_8000_0000;
    phase     = turn_prod[63:32];
    biased    = phase + 32'h2000_0000;
    quadrant  = biased[31:30];
    resid_u   = phase - {quadrant, 30'd0};
    resid     = longint'(signed'(resid_u));
    z         = round_shr(resid * longint'(HALF_PI_Q30), 30);
    cx        = longint'(CORDIC_GAIN);
    cy        = 0;
    for (int unsigned i = 0; i < STEPS && i < 31; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx;
        cy += dy;
        z  -= longint'(ATAN_Q30[i]);
      end else begin
        cx += dx;
        cy -= dy;
        z  += longint'(ATAN_Q30[i]);
      end
    end
    case (quadrant)
      2'd0: begin
        cos_q30 = cx;
        sin_q30 = cy;
      end
      2'd1: begin
        cos_q30 = -cy;
        sin_q30 = cx;
      end
      2'd2: begin
        cos_q30 = -cx;
        sin_q30 = -cy;
      end
      default: begin
        cos_q30 = cy;
        sin_q30 = -cx;
      end
    endcase
  endfunction

  // A Q30 sum rounded to the output format and saturated to plus or minus 1.0.
  function automatic logic [OUT_W-1:0] to_entry(input longint v);
    longint lim;
    longint o;
    lim = longint'(1) <<< FRAC;
    o   = round_shr(v, 30 - FRAC);
    if (o > lim) o = lim;
    if (o < -lim) o = -lim;
    return o[OUT_W-1:0];
  endfunction

  function automatic matrix_t zxy_matrix(input logic signed [ANGLE_W-1:0] a,
                                         input logic signed [ANGLE_W-1:0] b,
                                         input logic signed [ANGLE_W-1:0] c,
                                         input logic in_degrees);
    longint  sa, ca, sb, cb, sc, cc;
    matrix_t m;
    angle_sin_cos(a, in_degrees, sa, ca);
    angle_sin_cos(b, in_degrees, sb, cb);
    angle_sin_cos(c, in_degrees, sc, cc);
    m[0] = to_entry(mul_q30(ca, cc) - mul_q30(mul_q30(sa, sb), sc));
    m[1] = to_entry(-mul_q30(cb, sa));
    m[2] = to_entry(mul_q30(ca, sc) + mul_q30(mul_q30(cc, sa), sb));
    m[3] = to_entry(mul_q30(cc, sa) + mul_q30(mul_q30(ca, sb), sc));
    m[4] = to_entry(mul_q30(ca, cb));
    m[5] = to_entry(mul_q30(sa, sc) - mul_q30(mul_q30(ca, cc), sb));
    m[6] = to_entry(-mul_q30(cb, sc));
    m[7] = to_entry(sb);
    m[8] = to_entry(mul_q30(cb, cc));
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // Prediction and checking. Both processes sample at the rising edge, where
  // they see the values from before the edge, exactly as the block does.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && ang_if.valid && ang_if.ready) begin
      expected_mats.push_back(zxy_matrix(ang_if.angle_a, ang_if.angle_b,
                                         ang_if.angle_c, ang_if.angles_in_degrees));
    end
  end

  task automatic note_mismatch(input string what, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
    if (mismatch_count < MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s expected %0d (0x%h), got %0d (0x%h)",
               cycle_count, what, $signed(want), want, $signed(got), got);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    matrix_t got;
    matrix_t want;
    if (rst_n && mat_if.valid && mat_if.ready) begin
      got = {mat_if.entry_r2c2, mat_if.entry_r2c1, mat_if.entry_r2c0,
             mat_if.entry_r1c2, mat_if.entry_r1c1, mat_if.entry_r1c0,
             mat_if.entry_r0c2, mat_if.entry_r0c1, mat_if.entry_r0c0};
      if (expected_mats.size() == 0) begin
        // A matrix transfer that no angle transfer accounts for.
        note_mismatch("unexpected matrix, entry r0c0", '0, got[0]);
      end else begin
        want = expected_mats.pop_front();
        for (int k = 0; k < N_ENTRY; k++) begin
          if (got[k] !== want[k]) note_mismatch({"entry ", entry_names[k]}, want[k], got[k]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // The matrix side stalls in random bursts, and stops stalling altogether
  // once the quiet part of the run begins. This process alone drives ready.
  // ---------------------------------------------------------------------------
  initial begin
    mat_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        mat_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        mat_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sends one set of angles. It is entered at a rising edge and returns at the
  // edge of its transfer, so valid is only ever written once per edge: it
  // stays high straight into the next item unless a gap is drawn.
  // ---------------------------------------------------------------------------
  task automatic send_angles(input logic signed [ANGLE_W-1:0] a,
                             input logic signed [ANGLE_W-1:0] b,
                             input logic signed [ANGLE_W-1:0] c,
                             input logic in_degrees);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      ang_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ang_if.valid             <= 1'b1;
    ang_if.angle_a           <= a;
    ang_if.angle_b           <= b;
    ang_if.angle_c           <= c;
    ang_if.angles_in_degrees <= in_degrees;
    do @(posedge clk); while (!ang_if.ready);
  endtask

  // One random angle. Four in ten are in the everyday range of a turn or two,
  // three in ten sit close to a multiple of an eighth of a turn, and the rest
  // are any 32-bit pattern, which wraps round many turns.
  function automatic logic signed [ANGLE_W-1:0] random_angle(input logic in_degrees);
    int unsigned pick;
    int          k;
    int          offset;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      if (in_degrees) return int'($urandom_range(0, 720 * Q16_ONE)) - 360 * Q16_ONE;
      return int'($urandom_range(0, 14 * Q16_ONE)) - 7 * Q16_ONE;
    end else if (pick < 7) begin
      // Multiples of an eighth of a turn, give or take a few LSBs, so that
      // the quadrant split and the residual sign are both at their edges.
      k      = int'($urandom_range(0, 16)) - 8;
      offset = int'($urandom_range(0, 16)) - 8;
      if (in_degrees) return k * 45 * Q16_ONE + offset;
      return k * 51472 + offset * 8;
    end
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // Test tasks.
  // ---------------------------------------------------------------------------

  // Extremes of the angle fields in both units, plus the smallest steps
  // either side of zero.
  task automatic test_field_extremes();
    send_angles(32'sd0, 32'sd0, 32'sd0, 1'b0);
    send_angles(32'sd0, 32'sd0, 32'sd0, 1'b1);
    send_angles(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    send_angles(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_angles(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    send_angles(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    send_angles(32'sd1, -32'sd1, 32'sd1, 1'b0);
    send_angles(-32'sd1, 32'sd1, -32'sd1, 1'b1);
  endtask

  // Multiples of 45 degrees and their neighbours; at right angles the entries
  // land on exactly plus or minus 1.0 and any CORDIC overshoot must be clamped.
  task automatic test_right_angles();
    send_angles(90 * Q16_ONE, 0, 0, 1'b1);
    send_angles(0, 90 * Q16_ONE, 0, 1'b1);
    send_angles(0, 0, 90 * Q16_ONE, 1'b1);
    send_angles(-90 * Q16_ONE, 180 * Q16_ONE, 270 * Q16_ONE, 1'b1);
    send_angles(45 * Q16_ONE, -45 * Q16_ONE, 135 * Q16_ONE, 1'b1);
    send_angles(360 * Q16_ONE, -360 * Q16_ONE, 720 * Q16_ONE, 1'b1);
    send_angles(45 * Q16_ONE - 1, 45 * Q16_ONE + 1, -45 * Q16_ONE - 1, 1'b1);
  endtask

  // The same landmarks in radians, in Q16.16: plus and minus pi/2, pi and pi/4.
  task automatic test_radian_landmarks();
    send_angles(32'sd102944, 32'sd0, 32'sd0, 1'b0);
    send_angles(32'sd0, 32'sd102944, 32'sd205887, 1'b0);
    send_angles(-32'sd102944, -32'sd205887, 32'sd51472, 1'b0);
    send_angles(32'sd51472, 32'sd51471, -32'sd51472, 1'b0);
  endtask

  // Random angles, with idling on both sides unless the run is quiet.
  task automatic test_random_angles(input int unsigned count);
    logic in_degrees;
    for (int unsigned n = 0; n < count; n++) begin
      in_degrees = 1'($urandom_range(0, 1));
      send_angles(random_angle(in_degrees), random_angle(in_degrees),
                  random_angle(in_degrees), in_degrees);
    end
  endtask

  // The closing stretch: no idling on either side, so the pipeline runs
  // full with a transfer on every cycle.
  task automatic test_back_to_back(input int unsigned count);
    quiet = 1'b1;
    test_random_angles(count);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    quiet          = 1'b0;
    rst_n                    <= 1'b0;
    ang_if.valid             <= 1'b0;
    ang_if.angle_a           <= '0;
    ang_if.angle_b           <= '0;
    ang_if.angle_c           <= '0;
    ang_if.angles_in_degrees <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_right_angles();
    test_radian_landmarks();
    test_random_angles(800);
    test_back_to_back(300);
    ang_if.valid <= 1'b0;

    // Let the pipeline drain, then watch a little longer for strays.
    while (expected_mats.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    if (mismatch_count == 0 && expected_mats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
